/* rtl/glzw_pkg.sv */
// ---------------------------------------------------------------------------
// glzw_pkg
// Shared types and constants of the GIF LZW stream decoder.
// ---------------------------------------------------------------------------
package glzw_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int STACK_DEPTH_DEF   = 4096;
  localparam int MAX_WIDTH_LIMIT   = 4096;

  localparam logic [3:0] ROOT_MIN  = 4'd2;
  localparam logic [3:0] ROOT_MAX  = 4'd8;
  localparam logic [3:0] ROOT_RST  = 4'd8;
  localparam int         BYTE_ROOM = 16;   // most bits held before a data byte still fits

  // input beat opcodes
  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_PIXEL     = 3'd0,
    ST_NEED      = 3'd1,
    ST_END       = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_CORRUPT   = 3'd4,
    ST_TAKEN     = 3'd5,
    ST_REFUSED   = 3'd6
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PULL,
    S_POP,
    S_DECODE,
    S_WALK,
    S_WALK_RD,
    S_RESP
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_PUSH,
    DP_START,
    DP_POP_RD,
    DP_EXTRACT,
    DP_INIT,
    DP_END,
    DP_FIRST,
    DP_KWK,
    DP_NORM,
    DP_WALK_RD,
    DP_WALK_STEP,
    DP_FINISH,
    DP_FLUSH,
    DP_ROOT_FULL
  } dp_op_t;

  typedef enum logic [1:0] {
    PIX_ZERO,
    PIX_STACK,
    PIX_CODE
  } pix_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     res_load;
    status_t  res_status;
    pix_sel_t pix_sel;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic end_seen;
    logic framing_done;
    logic push_refuse;
    logic stack_empty;
    logic stack_full;
    logic bits_short;
    logic code_clr;
    logic code_end;
    logic awaiting;
    logic code_root;
    logic code_new;
    logic cur_root;
    logic cur_oob;
    logic link_self;
  } dp_sts_t;

endpackage

/* rtl/glzw_if.sv */
// ---------------------------------------------------------------------------
// glzw_if
// Channel interfaces: command input, result output, configuration write.
// ---------------------------------------------------------------------------
interface glzw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface glzw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_index;
  logic [2:0] status;
  modport source (output valid, output pixel_index, output status, input ready);
  modport sink   (input valid, input pixel_index, input status, output ready);
endinterface

interface glzw_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] min_code_size;
  modport source (output valid, output min_code_size, input ready);
  modport sink   (input valid, input min_code_size, output ready);
endinterface

/* rtl/glzw_ctrl.sv */
// ---------------------------------------------------------------------------
// glzw_ctrl
// Sequencer: steps one command beat through pop, decode and chain walk.
// ---------------------------------------------------------------------------
module glzw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  glzw_pkg::dp_sts_t   sts,
  output glzw_pkg::ctrl_cmd_t cmd
);
  import glzw_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd == CMD_PULL) ? S_PULL : S_RESP;
        end
      end
      S_PULL: begin
        if (sts.end_seen) state_nxt = S_RESP;
        else if (!sts.stack_empty) state_nxt = S_POP;
        else if (sts.bits_short) state_nxt = S_RESP;
        else state_nxt = S_DECODE;
      end
      S_POP: state_nxt = S_RESP;
      S_DECODE: begin
        if (sts.code_clr) state_nxt = S_PULL;
        else if (sts.code_end || sts.awaiting) state_nxt = S_RESP;
        else if (sts.code_new && sts.stack_full) state_nxt = S_RESP;
        else state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.cur_root) state_nxt = sts.stack_full ? S_RESP : S_PULL;
        else if (sts.cur_oob) state_nxt = S_RESP;
        else state_nxt = S_WALK_RD;
      end
      S_WALK_RD: begin
        state_nxt = (sts.stack_full || sts.link_self) ? S_RESP : S_WALK;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '{op: DP_NOP, res_load: 1'b0, res_status: ST_PIXEL,
            pix_sel: PIX_ZERO, out_load: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_PUSH: begin
              cmd.op         = DP_PUSH;
              cmd.res_load   = 1'b1;
              cmd.res_status = sts.push_refuse ? ST_REFUSED : ST_TAKEN;
            end
            CMD_PULL: cmd.op = DP_NOP;
            CMD_START: begin
              cmd.op         = DP_START;
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_TAKEN;
            end
            default: begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_REFUSED;
            end
          endcase
        end
      end
      S_PULL: begin
        if (sts.end_seen) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_END;
        end else if (!sts.stack_empty) begin
          cmd.op = DP_POP_RD;
        end else if (sts.bits_short) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = sts.framing_done ? ST_EXHAUSTED : ST_NEED;
        end else begin
          cmd.op = DP_EXTRACT;
        end
      end
      S_POP: begin
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_PIXEL;
        cmd.pix_sel    = PIX_STACK;
      end
      S_DECODE: begin
        if (sts.code_clr) begin
          cmd.op = DP_INIT;
        end else if (sts.code_end) begin
          cmd.op         = DP_END;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_END;
        end else if (sts.awaiting) begin
          cmd.res_load = 1'b1;
          if (sts.code_root) begin
            cmd.op         = DP_FIRST;
            cmd.res_status = ST_PIXEL;
            cmd.pix_sel    = PIX_CODE;
          end else begin
            cmd.res_status = ST_CORRUPT;
          end
        end else if (sts.code_new) begin
          if (sts.stack_full) begin
            cmd.op         = DP_FLUSH;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_CORRUPT;
          end else begin
            cmd.op = DP_KWK;
          end
        end else begin
          cmd.op = DP_NORM;
        end
      end
      S_WALK: begin
        if (sts.cur_root && !sts.stack_full) begin
          cmd.op = DP_FINISH;
        end else if (sts.cur_root) begin
          // root reached with no room left: first character still updates
          cmd.op         = DP_ROOT_FULL;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_CORRUPT;
        end else if (sts.cur_oob) begin
          cmd.op         = DP_FLUSH;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_CORRUPT;
        end else begin
          cmd.op = DP_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (sts.stack_full || sts.link_self) begin
          cmd.op         = DP_FLUSH;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_CORRUPT;
        end else begin
          cmd.op = DP_WALK_STEP;
        end
      end
      S_RESP: begin
        cmd.out_load = !out_valid_r || out_ready;
      end
      default: cmd.op = DP_NOP;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/glzw_dp.sv */
// ---------------------------------------------------------------------------
// glzw_dp
// Datapath: bit buffer, code tables, string stack and result registers.
// ---------------------------------------------------------------------------
module glzw_dp #(
  parameter int TABLE_ENTRIES = glzw_pkg::TABLE_ENTRIES_DEF,
  parameter int STACK_DEPTH   = glzw_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_min_code_size,
  input  logic [7:0]          data_byte,
  input  glzw_pkg::ctrl_cmd_t cmd,
  output glzw_pkg::dp_sts_t   sts,
  output logic [7:0]          pixel_index,
  output logic [2:0]          status
);
  import glzw_pkg::*;

  localparam int TAW = $clog2(TABLE_ENTRIES);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = SAW + 1;
  localparam logic [12:0] NFC_RST = 13'(2 ** ROOT_RST + 2);
  localparam logic [12:0] WL_RST  = 13'(2 ** (ROOT_RST + 1));

  // memories
  logic [11:0] pfx_mem [TABLE_ENTRIES];
  logic [7:0]  sfx_mem [TABLE_ENTRIES];
  logic [7:0]  stk_mem [STACK_DEPTH];

  // state registers
  logic [3:0]     cfg_r, root_r, root_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [23:0]    buf_r, buf_nxt;
  logic [4:0]     bits_r, bits_nxt;
  logic [3:0]     cw_r, cw_nxt;
  logic [12:0]    nfc_r, nfc_nxt;
  logic [12:0]    wl_r, wl_nxt;
  logic [7:0]     first_r, first_nxt;
  logic [11:0]    prev_r, prev_nxt;
  logic           await_r, await_nxt;
  logic [7:0]     sub_r, sub_nxt;
  logic           framed_r, framed_nxt;
  logic           ended_r, ended_nxt;
  // payload registers
  logic [11:0]    code_r, code_nxt;
  logic [11:0]    cur_r, cur_nxt;
  logic [11:0]    incode_r, incode_nxt;
  status_t        res_status_r, res_status_nxt;
  logic [7:0]     res_pixel_r, res_pixel_nxt;
  logic [7:0]     out_pixel_r;
  status_t        out_status_r;
  logic [11:0]    pfx_rd_r;
  logic [7:0]     sfx_rd_r, stk_rd_r;

  logic [8:0]     clr;
  logic [3:0]     start_root, init_root;
  logic [8:0]     init_clr;
  logic           ent_valid;
  logic [11:0]    pfx_eff;
  logic [7:0]     sfx_eff;
  logic           stk_we, tab_we;
  logic [7:0]     stk_wdata;
  logic [SPW-1:0] sp_dec;
  logic [12:0]    nfc_inc;

  assign clr    = 9'd1 << root_r;
  assign sp_dec = sp_r - SPW'(1);
  assign nfc_inc = nfc_r + 13'd1;

  always_comb begin
    if (cfg_r < ROOT_MIN) start_root = ROOT_MIN;
    else if (cfg_r > ROOT_MAX) start_root = ROOT_MAX;
    else start_root = cfg_r;
  end
  assign init_root = (cmd.op == DP_START) ? start_root : root_r;
  assign init_clr  = 9'd1 << init_root;

  // table entries outside the live range read as cleared
  assign ent_valid = (cur_r >= ({3'b0, clr} + 12'd2)) && ({1'b0, cur_r} < nfc_r);
  assign pfx_eff   = ent_valid ? pfx_rd_r : 12'd0;
  assign sfx_eff   = ent_valid ? sfx_rd_r : 8'd0;

  // status to the sequencer
  always_comb begin
    sts.end_seen     = ended_r;
    sts.framing_done = framed_r;
    sts.push_refuse  = framed_r ||
                       ((sub_r != 8'd0) && !ended_r && (bits_r > 5'(BYTE_ROOM)));
    sts.stack_empty  = (sp_r == '0);
    sts.stack_full   = (sp_r >= SPW'(STACK_DEPTH));
    sts.bits_short   = (bits_r < {1'b0, cw_r});
    sts.code_clr     = (code_r == {3'b0, clr});
    sts.code_end     = (code_r == ({3'b0, clr} + 12'd1));
    sts.awaiting     = await_r;
    sts.code_root    = (code_r < {3'b0, clr});
    sts.code_new     = ({1'b0, code_r} >= nfc_r);
    sts.cur_root     = (cur_r < {3'b0, clr});
    sts.cur_oob      = ({1'b0, cur_r} >= 13'(TABLE_ENTRIES));
    sts.link_self    = (pfx_eff == cur_r);
  end

  // next-state logic for each datapath operation
  always_comb begin
    root_nxt   = root_r;
    sp_nxt     = sp_r;
    buf_nxt    = buf_r;
    bits_nxt   = bits_r;
    cw_nxt     = cw_r;
    nfc_nxt    = nfc_r;
    wl_nxt     = wl_r;
    first_nxt  = first_r;
    prev_nxt   = prev_r;
    await_nxt  = await_r;
    sub_nxt    = sub_r;
    framed_nxt = framed_r;
    ended_nxt  = ended_r;
    code_nxt   = code_r;
    cur_nxt    = cur_r;
    incode_nxt = incode_r;
    stk_we     = 1'b0;
    stk_wdata  = first_r;
    tab_we     = 1'b0;
    case (cmd.op)
      DP_PUSH: begin
        if (!framed_r) begin
          if (sub_r == 8'd0) begin
            if (data_byte == 8'd0) framed_nxt = 1'b1;
            else sub_nxt = data_byte;
          end else if (ended_r) begin
            sub_nxt = sub_r - 8'd1;
          end else if (bits_r <= 5'(BYTE_ROOM)) begin
            buf_nxt  = buf_r | ({16'd0, data_byte} << bits_r);
            bits_nxt = bits_r + 5'd8;
            sub_nxt  = sub_r - 8'd1;
          end
        end
      end
      DP_START, DP_INIT: begin
        root_nxt  = init_root;
        cw_nxt    = init_root + 4'd1;
        nfc_nxt   = {4'b0, init_clr} + 13'd2;
        wl_nxt    = {3'b0, init_clr, 1'b0};
        sp_nxt    = '0;
        await_nxt = 1'b1;
        if (cmd.op == DP_START) begin
          buf_nxt    = '0;
          bits_nxt   = '0;
          sub_nxt    = '0;
          framed_nxt = 1'b0;
          ended_nxt  = 1'b0;
          first_nxt  = '0;
          prev_nxt   = '0;
        end
      end
      DP_POP_RD: sp_nxt = sp_dec;
      DP_EXTRACT: begin
        code_nxt = buf_r[11:0] & ~(12'hFFF << cw_r);
        buf_nxt  = buf_r >> cw_r;
        bits_nxt = bits_r - {1'b0, cw_r};
      end
      DP_END: ended_nxt = 1'b1;
      DP_FIRST: begin
        first_nxt = code_r[7:0];
        prev_nxt  = code_r;
        await_nxt = 1'b0;
      end
      DP_KWK: begin
        stk_we     = 1'b1;
        stk_wdata  = first_r;
        sp_nxt     = sp_r + SPW'(1);
        cur_nxt    = prev_r;
        incode_nxt = code_r;
      end
      DP_NORM: begin
        cur_nxt    = code_r;
        incode_nxt = code_r;
      end
      DP_WALK_RD: cur_nxt = cur_r;
      DP_WALK_STEP: begin
        stk_we    = 1'b1;
        stk_wdata = sfx_eff;
        sp_nxt    = sp_r + SPW'(1);
        cur_nxt   = pfx_eff;
      end
      DP_FINISH: begin
        first_nxt = cur_r[7:0];
        stk_we    = 1'b1;
        stk_wdata = cur_r[7:0];
        sp_nxt    = sp_r + SPW'(1);
        prev_nxt  = incode_r;
        // add the new string and widen codes at the limit
        if (nfc_r < 13'(TABLE_ENTRIES)) begin
          tab_we  = 1'b1;
          nfc_nxt = nfc_inc;
          if ((nfc_inc >= wl_r) && (wl_r < 13'(MAX_WIDTH_LIMIT))) begin
            wl_nxt = {wl_r[11:0], 1'b0};
            cw_nxt = cw_r + 4'd1;
          end
        end
      end
      DP_FLUSH: sp_nxt = '0;
      DP_ROOT_FULL: begin
        first_nxt = cur_r[7:0];
        sp_nxt    = '0;
      end
      default: sp_nxt = sp_r;
    endcase
  end

  // result staging
  always_comb begin
    res_status_nxt = res_status_r;
    res_pixel_nxt  = res_pixel_r;
    if (cmd.res_load) begin
      res_status_nxt = cmd.res_status;
      case (cmd.pix_sel)
        PIX_STACK: res_pixel_nxt = stk_rd_r;
        PIX_CODE:  res_pixel_nxt = code_r[7:0];
        default:   res_pixel_nxt = 8'd0;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= ROOT_RST;
      root_r   <= ROOT_RST;
      sp_r     <= '0;
      buf_r    <= '0;
      bits_r   <= '0;
      cw_r     <= ROOT_RST + 4'd1;
      nfc_r    <= NFC_RST;
      wl_r     <= WL_RST;
      first_r  <= '0;
      prev_r   <= '0;
      await_r  <= 1'b1;
      sub_r    <= '0;
      framed_r <= 1'b0;
      ended_r  <= 1'b0;
    end else begin
      if (cfg_we) cfg_r <= cfg_min_code_size;
      root_r   <= root_nxt;
      sp_r     <= sp_nxt;
      buf_r    <= buf_nxt;
      bits_r   <= bits_nxt;
      cw_r     <= cw_nxt;
      nfc_r    <= nfc_nxt;
      wl_r     <= wl_nxt;
      first_r  <= first_nxt;
      prev_r   <= prev_nxt;
      await_r  <= await_nxt;
      sub_r    <= sub_nxt;
      framed_r <= framed_nxt;
      ended_r  <= ended_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    cur_r        <= cur_nxt;
    incode_r     <= incode_nxt;
    res_status_r <= res_status_nxt;
    res_pixel_r  <= res_pixel_nxt;
    if (cmd.out_load) begin
      out_pixel_r  <= res_pixel_r;
      out_status_r <= res_status_r;
    end
  end

  // code tables: one write, one registered read
  always_ff @(posedge clk) begin
    if (tab_we) begin
      pfx_mem[nfc_r[TAW-1:0]] <= prev_r;
      sfx_mem[nfc_r[TAW-1:0]] <= cur_r[7:0];
    end
    if (cmd.op == DP_WALK_RD) begin
      pfx_rd_r <= pfx_mem[cur_r[TAW-1:0]];
      sfx_rd_r <= sfx_mem[cur_r[TAW-1:0]];
    end
  end

  // string stack
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[sp_r[SAW-1:0]] <= stk_wdata;
    if (cmd.op == DP_POP_RD) stk_rd_r <= stk_mem[sp_dec[SAW-1:0]];
  end

  assign pixel_index = out_pixel_r;
  assign status      = out_status_r;

endmodule

/* rtl/gif_lzw_stream_decoder_unit.sv */
// ---------------------------------------------------------------------------
// gif_lzw_stream_decoder_unit
// GIF LZW image stream decoder, variable code width up to 12 bits.
// ---------------------------------------------------------------------------
// Each input beat gives exactly one result beat. Push, start and unknown
// commands go straight to the response state; a pull served from the string
// stack answers after one registered stack read. A pull that takes the first
// code after a start or clear, or meets an end code, answers from the decode
// step; any other decoded code walks its chain, where every link is one
// registered read of the code tables followed by a stack push; the string
// then comes out one pixel per pull from the stack. A clear code resets the
// tables and the pull goes on to decode the next code. Table reset needs no
// clearing pass: entries outside the range written since the last clear read
// as empty. One beat is worked at a time; a finished result sits in the
// output register while the next beat is taken. Configuration is taken in
// any cycle and used at start.
// ---------------------------------------------------------------------------
module gif_lzw_stream_decoder_unit #(
  parameter int TABLE_ENTRIES = glzw_pkg::TABLE_ENTRIES_DEF,
  parameter int STACK_DEPTH   = glzw_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  glzw_in_if.sink           in_ch,
  glzw_out_if.source        out_ch,
  glzw_cfg_if.sink          cfg_ch
);
  import glzw_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  assign cfg_ch.ready = 1'b1;

  glzw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (dp_sts),
    .cmd       (ctrl_cmd)
  );

  glzw_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .STACK_DEPTH   (STACK_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_ch.valid),
    .cfg_min_code_size (cfg_ch.min_code_size),
    .data_byte         (in_ch.data_byte),
    .cmd               (ctrl_cmd),
    .sts               (dp_sts),
    .pixel_index       (out_ch.pixel_index),
    .status            (out_ch.status)
  );

endmodule

/* rtl/glzw_chk.sv */
// ---------------------------------------------------------------------------
// glzw_chk
// Port-level checks of the decoder's result channel, bound to the top level.
// ---------------------------------------------------------------------------
module glzw_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] pixel_index,
  input logic [2:0] status
);
  import glzw_pkg::*;

  // no result beat right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // status code stays within the defined set
  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status <= ST_REFUSED))
    else $error("undefined status code");

  // non-pixel results carry a zero index
  a_pix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status != ST_PIXEL)) |-> (pixel_index == 8'd0))
    else $error("index set on non-pixel result");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(pixel_index) && $stable(status)))
    else $error("stalled result beat changed");

endmodule

bind gif_lzw_stream_decoder_unit glzw_chk u_glzw_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pixel_index (out_ch.pixel_index),
  .status      (out_ch.status)
);
